@@ src/tdm_pkg.sv @@
`default_nettype none

package tdm_pkg;

    // Sizing of the recognizer tables.
    localparam int MAX_STATES  = 128;
    localparam int MAX_SYMBOLS = 16;
    localparam int MAX_LEN     = 1024;

    // Field widths of the transaction payloads.
    localparam int CMD_W   = 3;
    localparam int STATE_W = 7;
    localparam int SYM_W   = 4;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 11;

    // Derived table geometry.
    localparam int ST_AW     = $clog2(MAX_STATES);
    localparam int TR_DEPTH  = MAX_STATES * MAX_SYMBOLS;
    localparam int TR_AW     = $clog2(TR_DEPTH);
    localparam int TR_W      = STATE_W + 1;
    localparam int MAP_DEPTH = 1 << BYTE_W;
    localparam int MAP_W     = SYM_W + 1;
    localparam int CNT_W     = $clog2(MAX_LEN + 1);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_LOAD_TRANS = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_MAP   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_ACCEPT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_START      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CHAR       = 3'd4;
    localparam logic [CMD_W-1:0] CMD_END        = 3'd5;

    // True when a state number addresses a real table row.
    function automatic logic state_in_range(input logic [STATE_W-1:0] s);
        return (32'(s) < MAX_STATES);
    endfunction

    // True when a symbol position addresses a real table column.
    function automatic logic sym_in_range(input logic [SYM_W-1:0] s);
        return (32'(s) < MAX_SYMBOLS);
    endfunction

    // Row-major address into the transition table.
    function automatic logic [TR_AW-1:0] tr_addr(input logic [STATE_W-1:0] s,
                                                 input logic [SYM_W-1:0] y);
        return TR_AW'(TR_AW'(s) * TR_AW'(MAX_SYMBOLS) + TR_AW'(y));
    endfunction

endpackage

`default_nettype wire

@@ src/table_driven_dfa_matcher_core.sv @@
`default_nettype none

// Programmable DFA recognizer. Commands enter on the s_ channel at one transaction per clock:
// the symbol map is read in the cycle a command is accepted, the transition table and the
// accepting flags while it sits in stage 1, and the run state (state, halt flag, count) is
// updated as it leaves stage 2, where an end command also loads the result register that drives
// the m_ channel. The rate of one character per cycle while nothing stalls is set by the loop
// from the transition memory's registered read data back to its read address, which forwards
// the state of the character just ahead. Input is refused only while an end command sits in the
// last stage and the previous result has not been taken yet. All tables come up usable right
// after reset with no clearing pass: the symbol map and the accepting flags read as invalid
// until written, while a transition entry must be loaded before any character can reach it.
module table_driven_dfa_matcher_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [tdm_pkg::CMD_W-1:0]     s_command,
    input  wire logic [tdm_pkg::STATE_W-1:0]   s_state_index,
    input  wire logic [tdm_pkg::SYM_W-1:0]     s_symbol_index,
    input  wire logic [tdm_pkg::STATE_W-1:0]   s_next_state,
    input  wire logic                          s_entry_valid,
    input  wire logic [tdm_pkg::BYTE_W-1:0]    s_char_byte,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_accepted,
    output logic      [tdm_pkg::LEN_W-1:0]     m_lexeme_length
);

    // Pipeline control.
    logic adv;
    logic s_fire;

    // Stage 1 registers (symbol map data arrives here).
    logic                          s1_valid_reg;
    logic [tdm_pkg::CMD_W-1:0]     s1_cmd_reg;
    logic [tdm_pkg::STATE_W-1:0]   s1_state_index_reg;
    logic [tdm_pkg::SYM_W-1:0]     s1_symbol_index_reg;
    logic [tdm_pkg::STATE_W-1:0]   s1_next_state_reg;
    logic                          s1_entry_valid_reg;
    logic                          s1_map_written_reg;

    // Stage 2 registers (transition and accepting data arrive here).
    logic                          s2_valid_reg;
    logic [tdm_pkg::CMD_W-1:0]     s2_cmd_reg;
    logic                          s2_fail_reg;
    logic                          s2_in_range_reg;
    logic                          s2_acc_written_reg;

    // Run state.
    logic [tdm_pkg::STATE_W-1:0]   state_reg;
    logic                          halted_reg;
    logic [tdm_pkg::CNT_W-1:0]     count_reg;

    // Result register.
    logic                          m_valid_reg;
    logic                          m_accepted_reg;
    logic [tdm_pkg::LEN_W-1:0]     m_length_reg;

    // Written marks for the tables that reset to invalid.
    logic [tdm_pkg::MAP_DEPTH-1:0]  map_written_reg;
    logic [tdm_pkg::MAX_STATES-1:0] acc_written_reg;

    // Memory ports.
    logic                          map_we;
    logic [tdm_pkg::MAP_W-1:0]     map_rdata;
    logic                          tr_we;
    logic [tdm_pkg::TR_AW-1:0]     tr_waddr;
    logic [tdm_pkg::TR_AW-1:0]     tr_raddr;
    logic [tdm_pkg::TR_W-1:0]      tr_rdata;
    logic                          acc_we;
    logic [tdm_pkg::ST_AW-1:0]     acc_waddr;
    logic [tdm_pkg::ST_AW-1:0]     acc_raddr;
    logic [0:0]                    acc_rdata;

    // Stage 1 decode.
    logic                          s1_map_ok;
    logic [tdm_pkg::SYM_W-1:0]     s1_sym;
    logic [tdm_pkg::STATE_W-1:0]   eff_state;
    logic                          eff_in_range;
    logic                          s1_fail;

    // Stage 2 decode.
    logic                          tr_ok;
    logic [tdm_pkg::STATE_W-1:0]   tr_next;
    logic                          s2_is_start;
    logic                          s2_adv_char;
    logic [tdm_pkg::CNT_W-1:0]     count_next;

    // The pipeline only waits when an end result would overwrite an untaken one.
    assign adv     = !(s2_valid_reg && (s2_cmd_reg == tdm_pkg::CMD_END) &&
                       m_valid_reg && !m_ready);
    assign s_ready = adv;
    assign s_fire  = s_valid && s_ready;

    // Symbol map loads write in the accept cycle, ahead of any later lookup.
    assign map_we = s_fire && (s_command == tdm_pkg::CMD_LOAD_MAP) &&
                    tdm_pkg::sym_in_range(s_symbol_index);

    tdm_ram #(
        .WIDTH (tdm_pkg::MAP_W),
        .DEPTH (tdm_pkg::MAP_DEPTH)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (s_char_byte),
        .wdata ({s_entry_valid, s_symbol_index}),
        .re    (adv),
        .raddr (s_char_byte),
        .rdata (map_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_written_reg <= '0;
        end else if (map_we) begin
            map_written_reg[s_char_byte] <= 1'b1;
        end
    end

    // Stage 0 to stage 1 transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_cmd_reg          <= s_command;
            s1_state_index_reg  <= s_state_index;
            s1_symbol_index_reg <= s_symbol_index;
            s1_next_state_reg   <= s_next_state;
            s1_entry_valid_reg  <= s_entry_valid;
            s1_map_written_reg  <= map_written_reg[s_char_byte];
        end
    end

    // The state seen by the stage 1 command is the one left by the stage 2 command.
    assign s2_is_start = s2_valid_reg && (s2_cmd_reg == tdm_pkg::CMD_START);
    assign tr_ok       = tr_rdata[tdm_pkg::TR_W-1];
    assign tr_next     = tr_rdata[tdm_pkg::STATE_W-1:0];
    assign s2_adv_char = s2_valid_reg && (s2_cmd_reg == tdm_pkg::CMD_CHAR) &&
                         !halted_reg && !s2_fail_reg && tr_ok;

    always_comb begin
        if (s2_is_start) begin
            eff_state = '0;
        end else if (s2_adv_char) begin
            eff_state = tr_next;
        end else begin
            eff_state = state_reg;
        end
    end

    // Character lookups that fail before the transition table is consulted.
    assign eff_in_range = tdm_pkg::state_in_range(eff_state);
    assign s1_map_ok    = s1_map_written_reg && map_rdata[tdm_pkg::MAP_W-1];
    assign s1_sym       = map_rdata[tdm_pkg::SYM_W-1:0];
    assign s1_fail      = !s1_map_ok || !eff_in_range || !tdm_pkg::sym_in_range(s1_sym);

    // Transition table: loads write and characters read in stage 1.
    assign tr_we    = adv && s1_valid_reg && (s1_cmd_reg == tdm_pkg::CMD_LOAD_TRANS) &&
                      tdm_pkg::state_in_range(s1_state_index_reg) &&
                      tdm_pkg::sym_in_range(s1_symbol_index_reg);
    assign tr_waddr = tdm_pkg::tr_addr(s1_state_index_reg, s1_symbol_index_reg);
    assign tr_raddr = tdm_pkg::tr_addr(eff_state, s1_sym);

    tdm_ram #(
        .WIDTH (tdm_pkg::TR_W),
        .DEPTH (tdm_pkg::TR_DEPTH)
    ) u_tr_ram (
        .aclk  (aclk),
        .we    (tr_we),
        .waddr (tr_waddr),
        .wdata ({s1_entry_valid_reg, s1_next_state_reg}),
        .re    (adv),
        .raddr (tr_raddr),
        .rdata (tr_rdata)
    );

    // Accepting flags: set in stage 1, read for the state an end command will see.
    assign acc_we    = adv && s1_valid_reg && (s1_cmd_reg == tdm_pkg::CMD_SET_ACCEPT) &&
                       tdm_pkg::state_in_range(s1_state_index_reg);
    assign acc_waddr = tdm_pkg::ST_AW'(s1_state_index_reg);
    assign acc_raddr = tdm_pkg::ST_AW'(eff_state);

    tdm_ram #(
        .WIDTH (1),
        .DEPTH (tdm_pkg::MAX_STATES)
    ) u_acc_ram (
        .aclk  (aclk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (s1_entry_valid_reg),
        .re    (adv),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_written_reg <= '0;
        end else if (acc_we) begin
            acc_written_reg[acc_waddr] <= 1'b1;
        end
    end

    // Stage 1 to stage 2 transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_cmd_reg         <= s1_cmd_reg;
            s2_fail_reg        <= s1_fail;
            s2_in_range_reg    <= eff_in_range;
            s2_acc_written_reg <= eff_in_range && acc_written_reg[acc_raddr];
        end
    end

    // Saturating character count.
    always_comb begin
        if (count_reg < tdm_pkg::CNT_W'(tdm_pkg::MAX_LEN)) begin
            count_next = count_reg + 1'b1;
        end else begin
            count_next = count_reg;
        end
    end

    // Stage 2 commits the command to the run state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= '0;
            halted_reg <= 1'b0;
            count_reg  <= '0;
        end else if (adv && s2_valid_reg) begin
            case (s2_cmd_reg)
                tdm_pkg::CMD_START: begin
                    state_reg  <= '0;
                    halted_reg <= 1'b0;
                    count_reg  <= '0;
                end
                tdm_pkg::CMD_CHAR: begin
                    if (!halted_reg) begin
                        if (s2_fail_reg || !tr_ok) begin
                            halted_reg <= 1'b1;
                        end else begin
                            state_reg <= tr_next;
                            count_reg <= count_next;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result register: loaded by an end command, emptied by the downstream transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv && s2_valid_reg && (s2_cmd_reg == tdm_pkg::CMD_END)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s2_valid_reg && (s2_cmd_reg == tdm_pkg::CMD_END)) begin
            m_accepted_reg <= s2_in_range_reg && s2_acc_written_reg && acc_rdata[0] &&
                              (count_reg != '0);
            m_length_reg   <= tdm_pkg::LEN_W'(count_reg);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_accepted      = m_accepted_reg;
    assign m_lexeme_length = m_length_reg;

    // A halted run keeps its state until a start reaches the commit stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg && !(adv && s2_is_start) |=> $stable(state_reg))
        else $error("state moved while the run was halted");

    // The count never passes its saturation value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= tdm_pkg::CNT_W'(tdm_pkg::MAX_LEN))
        else $error("character count above its limit");

    // An advancing character moves to its next state and bumps the count unless it is saturated.
    assert property (@(posedge aclk) disable iff (!aresetn)
        adv && s2_adv_char |=>
            (count_reg == $past(count_next)) && (state_reg == $past(tr_next)))
        else $error("advancing character did not update the run state");

    // An accepted result always carries a nonzero length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_accepted_reg |-> (m_length_reg != '0))
        else $error("accepted result with zero length");

    // A committed end command always presents a result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        adv && s2_valid_reg && (s2_cmd_reg == tdm_pkg::CMD_END) |=> m_valid_reg)
        else $error("end command produced no result");

endmodule

`default_nettype wire

@@ src/tdm_ram.sv @@
`default_nettype none

module tdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
